// File: hw/rtl/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared constants, command format and address helpers for the page
// framebuffer with axis bars.
// ----------------------------------------------------------------------------
`default_nettype none

package pfb_pkg;

   localparam int SCREEN_W    = 128;
   localparam int SCREEN_H    = 32;
   localparam int PAGES       = (SCREEN_H + 7) / 8;
   localparam int STORE_BYTES = SCREEN_W * PAGES;

   localparam int X_W    = $clog2(SCREEN_W);
   localparam int Y_W    = $clog2(SCREEN_H);
   localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int ADDR_W = $clog2(STORE_BYTES);
   localparam int BYTE_W = 8;

   localparam int POS_W      = 9;
   localparam int RADDR_W    = 9;
   localparam int COORD_W    = 11;
   localparam int CX_W       = 7;
   localparam int CY_W       = 5;
   localparam int CSR_DATA_W = 7;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CX_W-1:0] CENTER_X_RST = CX_W'(64);
   localparam logic [CY_W-1:0] CENTER_Y_RST = CY_W'(16);

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 1'b1;

   localparam logic [1:0] REQ_PIXEL = 2'd0;
   localparam logic [1:0] REQ_BARS  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_DRAW  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef struct packed {
      logic [1:0]        op;
      logic              clipped;
      logic              color;
      logic [X_W-1:0]    hx_lo;
      logic [X_W-1:0]    hx_hi;
      logic [PAGE_W-1:0] hpage;
      logic [BYTE_W-1:0] hmask;
      logic              vdo;
      logic [X_W-1:0]    vx;
      logic [Y_W-1:0]    vy_lo;
      logic [Y_W-1:0]    vy_hi;
      logic [ADDR_W-1:0] addr;
   } cmd_type;

   function automatic logic [PAGE_W-1:0] page_of(input logic [Y_W-1:0] y);
      return PAGE_W'(y >> 3);
   endfunction

   function automatic logic [ADDR_W-1:0] byte_addr(input logic [PAGE_W-1:0] page,
                                                   input logic [X_W-1:0] x);
      return ADDR_W'(ADDR_W'(page) * ADDR_W'(SCREEN_W) + ADDR_W'(x));
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pfb_front.sv
// ----------------------------------------------------------------------------
// pfb_front
// Takes requests, holds the centre registers and turns each request into a
// clipped command for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_type,
   input  logic signed [pfb_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [pfb_pkg::POS_W-1:0]    req_pos_y,
   input  logic                                req_color,
   input  logic [pfb_pkg::RADDR_W-1:0]         req_read_addr,
   input  logic                                csr_we,
   input  logic [pfb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pfb_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                q_full,
   input  logic                                init_busy,
   output logic                                push,
   output pfb_pkg::cmd_type                    cmd
);

   localparam int CW = pfb_pkg::COORD_W;
   localparam logic signed [CW-1:0] X_MAX = CW'(pfb_pkg::SCREEN_W - 1);
   localparam logic signed [CW-1:0] Y_MAX = CW'(pfb_pkg::SCREEN_H - 1);

   logic [pfb_pkg::CX_W-1:0] center_x_ff, center_x_in;
   logic [pfb_pkg::CY_W-1:0] center_y_ff, center_y_in;

   logic signed [CW-1:0] px, py, cx, cy, ex, ey;
   logic signed [CW-1:0] xlo, xhi, ylo, yhi, xlo_c, xhi_c, ylo_c, yhi_c;
   logic                 pix_on, clip_x, clip_y;

   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      if (csr_we) begin
         case (csr_index)
            pfb_pkg::CSR_CENTER_X: center_x_in = csr_wdata[pfb_pkg::CX_W-1:0];
            pfb_pkg::CSR_CENTER_Y: center_y_in = csr_wdata[pfb_pkg::CY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= pfb_pkg::CENTER_X_RST;
         center_y_ff <= pfb_pkg::CENTER_Y_RST;
      end else begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
      end
   end

   assign busy = q_full | init_busy;
   assign push = start & ~busy;

   always_comb begin
      px = CW'(req_pos_x);
      py = CW'(req_pos_y);
      cx = $signed(CW'(center_x_ff));
      cy = $signed(CW'(center_y_ff));
      ex = cx + px;
      ey = cy + py;
      xlo = (ex < cx) ? ex : cx;
      xhi = (ex < cx) ? cx : ex;
      ylo = (ey < cy) ? ey : cy;
      yhi = (ey < cy) ? cy : ey;
      clip_x = xlo[CW-1] | (xhi > X_MAX);
      clip_y = ylo[CW-1] | (yhi > Y_MAX);
      xlo_c = xlo[CW-1] ? '0 : xlo;
      xhi_c = (xhi > X_MAX) ? X_MAX : xhi;
      ylo_c = ylo[CW-1] ? '0 : ylo;
      yhi_c = (yhi > Y_MAX) ? Y_MAX : yhi;
      pix_on = ~px[CW-1] & ~py[CW-1] & (px <= X_MAX) & (py <= Y_MAX);

      cmd = '0;
      case (req_type)
         pfb_pkg::REQ_PIXEL: begin
            if (pix_on) begin
               cmd.op    = pfb_pkg::OP_DRAW;
               cmd.color = req_color;
               cmd.hx_lo = pfb_pkg::X_W'(px);
               cmd.hx_hi = pfb_pkg::X_W'(px);
               cmd.hpage = pfb_pkg::page_of(pfb_pkg::Y_W'(py));
               cmd.hmask = pfb_pkg::BYTE_W'(1) << py[2:0];
            end else begin
               cmd.op      = pfb_pkg::OP_NONE;
               cmd.clipped = 1'b1;
            end
         end
         pfb_pkg::REQ_BARS: begin
            cmd.op      = pfb_pkg::OP_DRAW;
            cmd.color   = 1'b1;
            cmd.clipped = clip_x | clip_y;
            cmd.hx_lo   = pfb_pkg::X_W'(xlo_c);
            cmd.hx_hi   = pfb_pkg::X_W'(xhi_c);
            cmd.hpage   = pfb_pkg::page_of(pfb_pkg::Y_W'(cy));
            cmd.hmask   = pfb_pkg::BYTE_W'(1) << cy[2:0];
            cmd.vdo     = 1'b1;
            cmd.vx      = pfb_pkg::X_W'(cx);
            cmd.vy_lo   = pfb_pkg::Y_W'(ylo_c);
            cmd.vy_hi   = pfb_pkg::Y_W'(yhi_c);
         end
         pfb_pkg::REQ_CLEAR: begin
            cmd.op = pfb_pkg::OP_CLEAR;
         end
         default: begin
            if ({1'b0, req_read_addr} <
                (pfb_pkg::RADDR_W + 1)'(pfb_pkg::STORE_BYTES)) begin
               cmd.op   = pfb_pkg::OP_READ;
               cmd.addr = pfb_pkg::ADDR_W'(req_read_addr);
            end else begin
               cmd.op      = pfb_pkg::OP_NONE;
               cmd.clipped = 1'b1;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/pfb_queue.sv
// ----------------------------------------------------------------------------
// pfb_queue
// Short command queue between the request front end and the drawing engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pfb_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output pfb_pkg::cmd_type pop_cmd,
   output logic             empty
);

   pfb_pkg::cmd_type entries_ff [pfb_pkg::QUEUE_DEPTH];

   logic [pfb_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pfb_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pfb_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   assign full    = (cnt_ff == pfb_pkg::QCNT_W'(pfb_pkg::QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign pop_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == pfb_pkg::QPTR_W'(pfb_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == pfb_pkg::QPTR_W'(pfb_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/pfb_ram.sv
// ----------------------------------------------------------------------------
// pfb_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [DATA_W-1:0]        wdata,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: hw/rtl/pfb_back.sv
// ----------------------------------------------------------------------------
// pfb_back
// Drawing engine: read-modify-write of frame store bytes for lines and
// pixels, clearing sweeps, byte reads, and the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  pfb_pkg::cmd_type            q_cmd,
   output logic                        q_pop,
   output logic                        init_busy,
   output logic                        rsp_valid,
   output logic [pfb_pkg::BYTE_W-1:0]  rsp_read_data,
   output logic                        rsp_clipped
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_HRD  = 3'd1;
   localparam logic [2:0] ST_HWR  = 3'd2;
   localparam logic [2:0] ST_VRD  = 3'd3;
   localparam logic [2:0] ST_VWR  = 3'd4;
   localparam logic [2:0] ST_CLR  = 3'd5;
   localparam logic [2:0] ST_RDW  = 3'd6;

   localparam logic [pfb_pkg::ADDR_W-1:0] LAST_ADDR =
      pfb_pkg::ADDR_W'(pfb_pkg::STORE_BYTES - 1);

   logic [2:0]                  state_ff, state_in;
   logic                        init_ff, init_in;
   logic [pfb_pkg::ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   pfb_pkg::cmd_type            cmd_ff, cmd_in;
   logic [pfb_pkg::X_W-1:0]     x_ff, x_in;
   logic [pfb_pkg::PAGE_W-1:0]  page_ff, page_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [pfb_pkg::BYTE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                        rsp_clip_ff, rsp_clip_in;

   logic                        ram_we;
   logic [pfb_pkg::ADDR_W-1:0]  ram_addr;
   logic [pfb_pkg::BYTE_W-1:0]  ram_wdata, ram_rdata;

   logic [2:0]                  lo_bit, hi_bit;
   logic [pfb_pkg::BYTE_W-1:0]  vmask;

   pfb_ram #(
      .DATA_W (pfb_pkg::BYTE_W),
      .DEPTH  (pfb_pkg::STORE_BYTES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign init_busy     = init_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_clipped   = rsp_clip_ff;

   always_comb begin
      lo_bit = (page_ff == pfb_pkg::page_of(cmd_ff.vy_lo)) ? cmd_ff.vy_lo[2:0] : 3'd0;
      hi_bit = (page_ff == pfb_pkg::page_of(cmd_ff.vy_hi)) ? cmd_ff.vy_hi[2:0] : 3'd7;
      vmask  = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));
   end

   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      clr_cnt_in   = clr_cnt_ff;
      cmd_in       = cmd_ff;
      x_in         = x_ff;
      page_in      = page_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_clip_in  = rsp_clip_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_addr     = pfb_pkg::byte_addr(cmd_ff.hpage, x_ff);
      ram_wdata    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               case (q_cmd.op)
                  pfb_pkg::OP_DRAW: begin
                     x_in     = q_cmd.hx_lo;
                     state_in = ST_HRD;
                  end
                  pfb_pkg::OP_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in   = ST_CLR;
                  end
                  pfb_pkg::OP_READ: begin
                     ram_addr = q_cmd.addr;
                     state_in = ST_RDW;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     rsp_clip_in  = q_cmd.clipped;
                  end
               endcase
            end
         end
         ST_HRD: begin
            state_in = ST_HWR;
         end
         ST_HWR: begin
            ram_we    = 1'b1;
            ram_wdata = cmd_ff.color ? (ram_rdata | cmd_ff.hmask)
                                     : (ram_rdata & ~cmd_ff.hmask);
            if (x_ff == cmd_ff.hx_hi) begin
               if (cmd_ff.vdo) begin
                  page_in  = pfb_pkg::page_of(cmd_ff.vy_lo);
                  state_in = ST_VRD;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_clip_in  = cmd_ff.clipped;
                  state_in     = ST_IDLE;
               end
            end else begin
               x_in     = x_ff + 1'b1;
               state_in = ST_HRD;
            end
         end
         ST_VRD: begin
            ram_addr = pfb_pkg::byte_addr(page_ff, cmd_ff.vx);
            state_in = ST_VWR;
         end
         ST_VWR: begin
            ram_addr  = pfb_pkg::byte_addr(page_ff, cmd_ff.vx);
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | vmask;
            if (page_ff == pfb_pkg::page_of(cmd_ff.vy_hi)) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_clip_in  = cmd_ff.clipped;
               state_in     = ST_IDLE;
            end else begin
               page_in  = page_ff + 1'b1;
               state_in = ST_VRD;
            end
         end
         ST_CLR: begin
            ram_addr  = clr_cnt_ff;
            ram_we    = 1'b1;
            ram_wdata = '0;
            if (clr_cnt_ff == LAST_ADDR) begin
               init_in  = 1'b0;
               state_in = ST_IDLE;
               if (!init_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_clip_in  = 1'b0;
               end
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_RDW: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = ram_rdata;
            rsp_clip_in  = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         init_ff      <= 1'b1;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      x_ff        <= x_in;
      page_ff     <= page_in;
      rsp_data_ff <= rsp_data_in;
      rsp_clip_ff <= rsp_clip_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/page_framebuffer_with_axis_bars_unit.sv
// ----------------------------------------------------------------------------
// page_framebuffer_with_axis_bars_unit
// 128x32 monochrome page-organized frame store with pixel writes, axis bar
// drawing from a configured centre, clearing and byte reads.
// ----------------------------------------------------------------------------
//
//   channel   ports                                     handshake
//   request   req_type req_pos_x req_pos_y req_color    start, busy
//             req_read_addr
//   result    rsp_read_data rsp_clipped                 rsp_valid strobe
//   config    csr_index csr_wdata                       csr_we
//
// A request is transferred when start is high and busy is low; it goes into
// a two-entry command queue, and the drawing engine works one command at a
// time through the single frame store port, reading each byte that a line
// or pixel touches and then writing it back. An off-screen pixel or bad
// address only returns a clipped result. After reset the store is swept to
// zero with busy high. Results appear for one cycle on rsp_valid; the
// receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module page_framebuffer_with_axis_bars_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_type,
   input  logic signed [pfb_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [pfb_pkg::POS_W-1:0]   req_pos_y,
   input  logic                               req_color,
   input  logic [pfb_pkg::RADDR_W-1:0]        req_read_addr,
   output logic                               rsp_valid,
   output logic [pfb_pkg::BYTE_W-1:0]         rsp_read_data,
   output logic                               rsp_clipped,
   input  logic                               csr_we,
   input  logic [pfb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pfb_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic             push, pop, q_full, q_empty, init_busy;
   pfb_pkg::cmd_type push_cmd, pop_cmd;

   pfb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_color     (req_color),
      .req_read_addr (req_read_addr),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .q_full        (q_full),
      .init_busy     (init_busy),
      .push          (push),
      .cmd           (push_cmd)
   );

   pfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   pfb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_cmd         (pop_cmd),
      .q_pop         (pop),
      .init_busy     (init_busy),
      .rsp_valid     (rsp_valid),
      .rsp_read_data (rsp_read_data),
      .rsp_clipped   (rsp_clipped)
   );

   a_init_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("busy low right after reset");

   a_no_rsp_during_init: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !rsp_valid)
      else $error("result strobe during initial store sweep");

   a_clip_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> rsp_read_data == '0)
      else $error("clipped result carries nonzero data");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full && !pop |=> !(q_full && $past(push)))
      else $error("queue overrun");

endmodule

`default_nettype wire
